FILE: src/orv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orv_pkg
// Shared types and codes of the outpoint run validator.
// ----------------------------------------------------------------------------
package orv_pkg;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_SPEND  = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_COIN          = 2'd0,
        KIND_OK            = 2'd1,
        KIND_COLLISION     = 2'd2,
        KIND_SPEND_UNKNOWN = 2'd3
    } t_kind;

    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [1:0]       mode;
        logic [3:0][63:0] txid;
        logic [31:0]      out_index;
        logic [63:0]      event_seq;
        logic [30:0]      block_height;
        logic [62:0]      coin_value;
        logic             from_coinbase;
        logic [15:0]      script_length;
        logic [31:0]      script_offset;
    } t_event;

    typedef struct packed {
        t_kind              kind;
        logic [3:0][63:0]   txid;
        logic [31:0]        out_index;
        logic [63:0]        value_or_seq;
        logic signed [31:0] height;
        logic               coinbase;
        logic [15:0]        script_length;
        logic [31:0]        script_offset;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_emit;

endpackage

FILE: src/orv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orv_event_if / orv_result_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface orv_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] txid_w0;
    logic [63:0] txid_w1;
    logic [63:0] txid_w2;
    logic [63:0] txid_w3;
    logic [31:0] out_index;
    logic [63:0] event_seq;
    logic [30:0] block_height;
    logic [62:0] coin_value;
    logic        from_coinbase;
    logic [15:0] script_length;
    logic [31:0] script_offset;

    modport source (
        output valid, mode, txid_w0, txid_w1, txid_w2, txid_w3, out_index,
               event_seq, block_height, coin_value, from_coinbase,
               script_length, script_offset,
        input  ready
    );
    modport sink (
        input  valid, mode, txid_w0, txid_w1, txid_w2, txid_w3, out_index,
               event_seq, block_height, coin_value, from_coinbase,
               script_length, script_offset,
        output ready
    );
endinterface

interface orv_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [63:0]        coin_txid_w0;
    logic [63:0]        coin_txid_w1;
    logic [63:0]        coin_txid_w2;
    logic [63:0]        coin_txid_w3;
    logic [31:0]        coin_out_index;
    logic [63:0]        value_or_seq;
    logic signed [31:0] height_out;
    logic               coin_is_coinbase;
    logic [15:0]        coin_script_length;
    logic [31:0]        coin_script_offset;
    logic               last;

    modport source (
        output valid, result_kind, coin_txid_w0, coin_txid_w1, coin_txid_w2,
               coin_txid_w3, coin_out_index, value_or_seq, height_out,
               coin_is_coinbase, coin_script_length, coin_script_offset, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, coin_txid_w0, coin_txid_w1, coin_txid_w2,
               coin_txid_w3, coin_out_index, value_or_seq, height_out,
               coin_is_coinbase, coin_script_length, coin_script_offset, last,
        output ready
    );
endinterface

FILE: src/orv_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orv_core
// Run tracking, reject tracking and result formation for one event word.
// ----------------------------------------------------------------------------
module orv_core import orv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_fire,
    input  t_event i_evt,
    output t_emit  o_emit
);

    logic [3:0][63:0] r_run_txid,   n_run_txid;
    logic [31:0]      r_run_vout,   n_run_vout;
    logic             r_run_open,   n_run_open;
    logic             r_coin_live,  n_coin_live;
    logic             r_run_bad,    n_run_bad;
    logic [62:0]      r_held_value, n_held_value;
    logic [30:0]      r_held_height, n_held_height;
    logic             r_held_cb,    n_held_cb;
    logic [15:0]      r_held_slen,  n_held_slen;
    logic [31:0]      r_held_soff,  n_held_soff;
    logic             r_rej_seen,   n_rej_seen;
    logic             r_rej_spend,  n_rej_spend;
    logic [63:0]      r_rej_seq,    n_rej_seq;
    logic [30:0]      r_rej_height, n_rej_height;

    logic    same_run;
    logic    close_emit;
    logic    rej_better;
    logic    live_eff;
    t_result coin_res;
    t_result sum_res;

    assign same_run = r_run_open && (r_run_txid == i_evt.txid)
                      && (r_run_vout == i_evt.out_index);
    assign close_emit = r_run_open && !r_run_bad && r_coin_live;
    assign rej_better = !r_rej_seen || (i_evt.event_seq < r_rej_seq);

    always_comb begin
        coin_res               = '0;
        coin_res.kind          = KIND_COIN;
        coin_res.txid          = r_run_txid;
        coin_res.out_index     = r_run_vout;
        coin_res.value_or_seq  = {1'b0, r_held_value};
        coin_res.height        = $signed({1'b0, r_held_height});
        coin_res.coinbase      = r_held_cb;
        coin_res.script_length = r_held_slen;
        coin_res.script_offset = r_held_soff;
        coin_res.last          = 1'b1;

        sum_res      = '0;
        sum_res.last = 1'b1;
        if (r_rej_seen) begin
            sum_res.kind         = r_rej_spend ? KIND_SPEND_UNKNOWN : KIND_COLLISION;
            sum_res.value_or_seq = r_rej_seq;
            sum_res.height       = $signed({1'b0, r_rej_height});
        end else begin
            sum_res.kind         = KIND_OK;
            sum_res.value_or_seq = '0;
            sum_res.height       = -32'sd1;
        end
    end

    always_comb begin
        n_run_txid    = r_run_txid;
        n_run_vout    = r_run_vout;
        n_run_open    = r_run_open;
        n_coin_live   = r_coin_live;
        n_run_bad     = r_run_bad;
        n_held_value  = r_held_value;
        n_held_height = r_held_height;
        n_held_cb     = r_held_cb;
        n_held_slen   = r_held_slen;
        n_held_soff   = r_held_soff;
        n_rej_seen    = r_rej_seen;
        n_rej_spend   = r_rej_spend;
        n_rej_seq     = r_rej_seq;
        n_rej_height  = r_rej_height;
        live_eff      = same_run ? r_coin_live : 1'b0;
        o_emit        = '0;

        unique case (t_mode'(i_evt.mode))
            MODE_CREATE, MODE_SPEND: begin
                if (!same_run) begin
                    o_emit.count = {1'b0, close_emit};
                    o_emit.res0  = coin_res;
                    n_run_txid   = i_evt.txid;
                    n_run_vout   = i_evt.out_index;
                    n_run_open   = 1'b1;
                    n_run_bad    = 1'b0;
                end
                if ((t_mode'(i_evt.mode) == MODE_CREATE) == live_eff) begin
                    n_run_bad = 1'b1;
                    if (rej_better) begin
                        n_rej_seen   = 1'b1;
                        n_rej_spend  = !live_eff;
                        n_rej_seq    = i_evt.event_seq;
                        n_rej_height = i_evt.block_height;
                    end
                end
                if (t_mode'(i_evt.mode) == MODE_CREATE) begin
                    n_coin_live   = 1'b1;
                    n_held_value  = i_evt.coin_value;
                    n_held_height = i_evt.block_height;
                    n_held_cb     = i_evt.from_coinbase;
                    n_held_slen   = i_evt.script_length;
                    n_held_soff   = i_evt.script_offset;
                end else begin
                    n_coin_live = 1'b0;
                end
            end
            MODE_FLUSH: begin
                if (close_emit) begin
                    o_emit.count     = 2'd2;
                    o_emit.res0      = coin_res;
                    o_emit.res0.last = 1'b0;
                    o_emit.res1      = sum_res;
                end else begin
                    o_emit.count = 2'd1;
                    o_emit.res0  = sum_res;
                end
                n_run_open   = 1'b0;
                n_coin_live  = 1'b0;
                n_run_bad    = 1'b0;
                n_rej_seen   = 1'b0;
                n_rej_spend  = 1'b0;
                n_rej_seq    = '0;
                n_rej_height = '0;
            end
            MODE_NONE: begin
                o_emit.count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_coin_live <= 1'b0;
            r_run_bad   <= 1'b0;
            r_rej_seen  <= 1'b0;
        end else if (i_fire) begin
            r_run_open  <= n_run_open;
            r_coin_live <= n_coin_live;
            r_run_bad   <= n_run_bad;
            r_rej_seen  <= n_rej_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_run_txid    <= n_run_txid;
            r_run_vout    <= n_run_vout;
            r_held_value  <= n_held_value;
            r_held_height <= n_held_height;
            r_held_cb     <= n_held_cb;
            r_held_slen   <= n_held_slen;
            r_held_soff   <= n_held_soff;
            r_rej_spend   <= n_rej_spend;
            r_rej_seq     <= n_rej_seq;
            r_rej_height  <= n_rej_height;
        end
    end

    a_two_only_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.count == 2'd2) |-> (t_mode'(i_evt.mode) == MODE_FLUSH))
        else $error("two results from a non-flush word");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && t_mode'(i_evt.mode) == MODE_FLUSH) |=> (!r_rej_seen && !r_run_open))
        else $error("flush left run or reject state");

    a_create_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && t_mode'(i_evt.mode) == MODE_CREATE) |=> (r_run_open && r_coin_live))
        else $error("create did not leave a live open run");

    a_bad_needs_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_bad |-> (r_rej_seen && r_run_open))
        else $error("bad run without a recorded reject");

endmodule

FILE: src/orv_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orv_result_fifo
// Small result queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module orv_result_fifo import orv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_d0,
    input  t_result    i_d1,
    input  logic       i_pop,
    output logic       o_valid,
    output logic       o_room,
    output t_result    o_data
);

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr, n_wr;
    logic [RES_PTR_W-1:0]   r_rd, n_rd;
    logic [RES_CNT_W-1:0]   r_cnt, n_cnt;
    logic [RES_PTR_W-1:0]   wr_next;
    logic                   pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign wr_next = r_wr + RES_PTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + RES_PTR_W'(i_push_n);
        n_rd  = pop_ok ? (r_rd + RES_PTR_W'(1)) : r_rd;
        n_cnt = r_cnt + RES_CNT_W'(i_push_n) - RES_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_d0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_next] <= i_d1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RES_CNT_W'(i_push_n) + r_cnt) <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && i_push_n == 2'd0) |=> (r_cnt == $past(r_cnt) - RES_CNT_W'(1)))
        else $error("pop did not drop the count");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == RES_PTR_W'(r_cnt))
        else $error("queue pointers disagree with count");

endmodule

FILE: src/outpoint_run_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outpoint_run_validator
// Checks create/spend alternation over sorted outpoint runs of one shard.
//
// i_evt carries event words (create, spend, end-of-shard flush), sorted by
// outpoint then seq. o_res carries result words: a live coin for every run
// that closes clean and live, and at the flush a summary (ok, collision or
// spend unknown, with the smallest offending seq and its height). The last
// flag marks the final word caused by one event.
// An event word is taken into an input register, processed by the run
// logic once the result queue has room and written into a four-entry
// result queue, from whose head results leave on o_res. One event is
// taken every cycle while the queue has room; a flush that closes a live
// run yields two words, the coin and then the summary. The input register
// stalls when the result queue has fewer than two free entries, so a
// stall on o_res backs up into i_evt and no word is lost.
// Reset clears the run, the reject tracker and the queue; the first event
// after reset starts a fresh shard, as does the first event after a flush.
// ----------------------------------------------------------------------------
module outpoint_run_validator import orv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    orv_event_if.sink    i_evt,
    orv_result_if.source o_res
);

    logic    r_in_valid;
    t_event  r_in;
    logic    fire;
    logic    room;
    t_emit   emit;
    t_result head;

    assign fire        = r_in_valid && room;
    assign i_evt.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.mode <= MODE_NONE;
        end else if (i_evt.valid && i_evt.ready) begin
            r_in.mode          <= i_evt.mode;
            r_in.txid          <= {i_evt.txid_w3, i_evt.txid_w2, i_evt.txid_w1, i_evt.txid_w0};
            r_in.out_index     <= i_evt.out_index;
            r_in.event_seq     <= i_evt.event_seq;
            r_in.block_height  <= i_evt.block_height;
            r_in.coin_value    <= i_evt.coin_value;
            r_in.from_coinbase <= i_evt.from_coinbase;
            r_in.script_length <= i_evt.script_length;
            r_in.script_offset <= i_evt.script_offset;
        end
    end

    orv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_evt   (r_in),
        .o_emit  (emit)
    );

    orv_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (fire ? emit.count : 2'd0),
        .i_d0     (emit.res0),
        .i_d1     (emit.res1),
        .i_pop    (o_res.ready),
        .o_valid  (o_res.valid),
        .o_room   (room),
        .o_data   (head)
    );

    assign o_res.result_kind        = head.kind;
    assign o_res.coin_txid_w0       = head.txid[0];
    assign o_res.coin_txid_w1       = head.txid[1];
    assign o_res.coin_txid_w2       = head.txid[2];
    assign o_res.coin_txid_w3       = head.txid[3];
    assign o_res.coin_out_index     = head.out_index;
    assign o_res.value_or_seq       = head.value_or_seq;
    assign o_res.height_out         = head.height;
    assign o_res.coin_is_coinbase   = head.coinbase;
    assign o_res.coin_script_length = head.script_length;
    assign o_res.coin_script_offset = head.script_offset;
    assign o_res.last               = head.last;

endmodule
